### design/pfc_limited_advection_cell_update_defines.svh
// Assertion macros for the cell update pipeline
`ifndef PFC_LIMITED_ADVECTION_CELL_UPDATE_DEFINES_SVH
`define PFC_LIMITED_ADVECTION_CELL_UPDATE_DEFINES_SVH

// same-cycle implication, disabled while reset is applied
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is applied
`define PFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pfclacu_pkg.sv
package pfclacu_pkg;

    localparam int SAMPLE_BITS       = 32;
    localparam int COURANT_FRAC_BITS = 30;
    localparam int COURANT_BITS      = COURANT_FRAC_BITS + 2;

    localparam int LIM_W      = SAMPLE_BITS + 4;
    localparam int TERM_W     = SAMPLE_BITS + 3;
    localparam int FLUX_W     = TERM_W + 2;
    localparam int SUM_W      = FLUX_W + 2;
    localparam int FACTOR_W   = COURANT_BITS + 1;
    localparam int COEF_W     = COURANT_BITS;
    localparam int K_W        = COURANT_FRAC_BITS - 2;
    localparam int DIV6_IN_W  = COURANT_FRAC_BITS + 1;
    localparam int DIV6_SHIFT = DIV6_IN_W + 3;
    localparam int RECIP6_W   = DIV6_IN_W + 1;
    localparam int RQ_W       = LIM_W + 2 * FACTOR_W;
    localparam int WINDOW     = 5;
    localparam int STAGES     = 7;

    localparam logic [RECIP6_W-1:0] RECIP6 =
        RECIP6_W'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);

    typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
    typedef logic signed [COURANT_BITS-1:0] courant_t;
    typedef logic signed [K_W-1:0]          coef_k_t;
    typedef logic signed [FLUX_W-1:0]       flux_t;
    typedef logic signed [RQ_W-1:0]         wide_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } face_load_t;

    localparam courant_t COURANT_ONE = courant_t'(64'sd1 <<< COURANT_FRAC_BITS);
    localparam wide_t    RND_HALF    = wide_t'(64'sd1 <<< (COURANT_FRAC_BITS - 1));
    localparam sample_t  SAMPLE_MAX  = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam sample_t  SAMPLE_MIN  = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    // round a Courant-scaled product back to integer scale, half away from zero
    function automatic wide_t round_q(wide_t p);
        wide_t biased;
        biased = p + RND_HALF - wide_t'(p[RQ_W-1]);
        return biased >>> COURANT_FRAC_BITS;
    endfunction

endpackage

### design/pfclacu_face_flux.sv
module pfclacu_face_flux (
    input  logic                    clk,
    input  pfclacu_pkg::face_load_t load,
    input  pfclacu_pkg::sample_t    win [pfclacu_pkg::WINDOW],
    input  pfclacu_pkg::courant_t   nu,
    input  pfclacu_pkg::coef_k_t    k1,
    input  pfclacu_pkg::coef_k_t    k2,
    output pfclacu_pkg::flux_t      flux
);
    import pfclacu_pkg::*;

    typedef logic signed [LIM_W-1:0]  lim_t;
    typedef logic signed [TERM_W-1:0] term_t;

    function automatic lim_t lim_max(lim_t a, lim_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic lim_t lim_min(lim_t a, lim_t b);
        return (a < b) ? a : b;
    endfunction

    lim_t     top_next, bot_next;
    lim_t     top_reg, bot_reg;
    sample_t  fm1_reg, f0_reg, fp1_reg, fp2_reg;
    courant_t nu_reg;

    always_comb
    begin
        lim_t fm2, fm1, f0, fp1, fp2;
        lim_t hi1, hi2, lo1, lo2;
        fm2 = lim_t'(win[0]);
        fm1 = lim_t'(win[1]);
        f0  = lim_t'(win[2]);
        fp1 = lim_t'(win[3]);
        fp2 = lim_t'(win[4]);
        hi1 = lim_max(lim_max(fm1, f0), lim_min((fm1 <<< 1) - fm2, (f0 <<< 1) - fp1));
        hi2 = lim_max(lim_max(fp1, f0), lim_min((fp1 <<< 1) - fp2, (f0 <<< 1) - fm1));
        lo1 = lim_min(lim_min(fm1, f0), lim_max((fm1 <<< 1) - fm2, (f0 <<< 1) - fp1));
        lo2 = lim_min(lim_min(fp1, f0), lim_max((fp1 <<< 1) - fp2, (f0 <<< 1) - fm1));
        top_next = lim_max(hi1, hi2);
        bot_next = lim_max('0, lim_min(lo1, lo2));
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fm1_reg <= win[1];
            f0_reg  <= win[2];
            fp1_reg <= win[3];
            fp2_reg <= win[4];
            nu_reg  <= nu;
        end
    end

    lim_t    lp_next, lm_next;
    term_t   lead_next;
    sample_t lead_sel;
    logic signed [COURANT_BITS+SAMPLE_BITS-1:0] lead_prod;

    always_comb
    begin
        lim_t fm1, f0, fp1, fp2;
        fm1 = lim_t'(fm1_reg);
        f0  = lim_t'(f0_reg);
        fp1 = lim_t'(fp1_reg);
        fp2 = lim_t'(fp2_reg);
        if (nu_reg[COURANT_BITS-1])
        begin
            lp_next  = (f0 >= fp1) ? lim_min((f0 - bot_reg) <<< 1, f0 - fp1)
                                   : lim_max((f0 - top_reg) <<< 1, f0 - fp1);
            lm_next  = (fp1 >= fp2) ? lim_min((top_reg - f0) <<< 1, fp1 - fp2)
                                    : lim_max((bot_reg - f0) <<< 1, fp1 - fp2);
            lead_sel = fp1_reg;
        end
        else
        begin
            lp_next  = (fp1 >= f0) ? lim_min((f0 - bot_reg) <<< 1, fp1 - f0)
                                   : lim_max((f0 - top_reg) <<< 1, fp1 - f0);
            lm_next  = (f0 >= fm1) ? lim_min((top_reg - f0) <<< 1, f0 - fm1)
                                   : lim_max((bot_reg - f0) <<< 1, f0 - fm1);
            lead_sel = f0_reg;
        end
    end

    assign lead_prod = nu_reg * lead_sel;
    assign lead_next = TERM_W'(round_q(wide_t'(lead_prod)));

    lim_t  lp2_reg, lm2_reg, lp3_reg, lm3_reg;
    term_t lead2_reg, lead3_reg, lead4_reg;
    term_t t1_reg, t2_reg;
    flux_t flux_reg;

    logic signed [K_W+LIM_W-1:0] t1_prod, t2_prod;
    term_t t1_next, t2_next;

    assign t1_prod = k1 * lp3_reg;
    assign t2_prod = k2 * lm3_reg;
    assign t1_next = TERM_W'(round_q(wide_t'(t1_prod)));
    assign t2_next = TERM_W'(round_q(wide_t'(t2_prod)));

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            lp2_reg   <= lp_next;
            lm2_reg   <= lm_next;
            lead2_reg <= lead_next;
        end
        if (load.s3)
        begin
            lp3_reg   <= lp2_reg;
            lm3_reg   <= lm2_reg;
            lead3_reg <= lead2_reg;
        end
        if (load.s4)
        begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            lead4_reg <= lead3_reg;
        end
        if (load.s5)
        begin
            flux_reg <= FLUX_W'(lead4_reg) + FLUX_W'(t1_reg) + FLUX_W'(t2_reg);
        end
    end

    assign flux = flux_reg;

endmodule

### design/pfc_limited_advection_cell_update.sv
// Flux-conservative third-order advection update of one grid cell. Each transfer on the
// input side carries the six samples i-3..i+2 (signed, SAMPLE_BITS) and a signed Courant
// number; each output transfer carries the new centre sample, saturated to the sample range,
// and a flag that marks the clip. The block is a seven-stage pipeline: one cell enters per
// clock when nothing stalls. The depth is set by the coefficient chain (two rounded
// multiplies, then a rounded divide by six done as a reciprocal multiply) feeding the
// limited slope products of both faces. A stall from the output side holds only the
// stages that are full; empty stages keep taking input.
`include "pfc_limited_advection_cell_update_defines.svh"

module pfc_limited_advection_cell_update (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pfclacu_pkg::sample_t  sample_minus3,
    input  pfclacu_pkg::sample_t  sample_minus2,
    input  pfclacu_pkg::sample_t  sample_minus1,
    input  pfclacu_pkg::sample_t  sample_center,
    input  pfclacu_pkg::sample_t  sample_plus1,
    input  pfclacu_pkg::sample_t  sample_plus2,
    input  pfclacu_pkg::courant_t courant_number,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pfclacu_pkg::sample_t  updated_sample,
    output logic                  saturated
);
    import pfclacu_pkg::*;

    function automatic coef_k_t div6_round(logic signed [COEF_W-1:0] c);
        logic [COEF_W-1:0]             mag;
        logic [DIV6_IN_W-1:0]          m;
        logic [DIV6_IN_W+RECIP6_W-1:0] prod;
        logic [K_W-1:0]                q;
        mag  = c[COEF_W-1] ? COEF_W'(-c) : COEF_W'(c);
        m    = DIV6_IN_W'(mag) + DIV6_IN_W'(3);
        prod = m * RECIP6;
        q    = K_W'(prod >> DIV6_SHIFT);
        return c[COEF_W-1] ? -coef_k_t'(q) : coef_k_t'(q);
    endfunction

    logic [STAGES-1:0] valid_reg, valid_next, advance, feed, load;

    always_comb
    begin
        advance[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
        feed       = {valid_reg[STAGES-2:0], in_valid};
        load       = advance & feed;
        valid_next = load | (~advance & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !advance[0];
    assign out_valid = valid_reg[STAGES-1];

    courant_t nu_clamped;

    always_comb
    begin
        if (courant_number > COURANT_ONE)
        begin
            nu_clamped = COURANT_ONE;
        end
        else if (courant_number < -COURANT_ONE)
        begin
            nu_clamped = -COURANT_ONE;
        end
        else
        begin
            nu_clamped = courant_number;
        end
    end

    sample_t  win_reg [WINDOW+1];
    courant_t nu0_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            win_reg[0] <= sample_minus3;
            win_reg[1] <= sample_minus2;
            win_reg[2] <= sample_minus1;
            win_reg[3] <= sample_center;
            win_reg[4] <= sample_plus1;
            win_reg[5] <= sample_plus2;
            nu0_reg    <= nu_clamped;
        end
    end

    courant_t abs_nu0;
    logic signed [FACTOR_W-1:0] fa, fb, p1_next, p2_next, p1_reg, p2_reg;
    logic signed [COURANT_BITS+FACTOR_W-1:0] p1_prod, p2_prod;
    courant_t nu1_reg;

    assign abs_nu0 = nu0_reg[COURANT_BITS-1] ? -nu0_reg : nu0_reg;
    assign fa      = FACTOR_W'(COURANT_ONE) - FACTOR_W'(abs_nu0);
    assign fb      = FACTOR_W'(COURANT_ONE) - FACTOR_W'(nu0_reg);
    assign p1_prod = nu0_reg * fa;
    assign p2_prod = nu0_reg * fb;
    assign p1_next = FACTOR_W'(round_q(wide_t'(p1_prod)));
    assign p2_next = FACTOR_W'(round_q(wide_t'(p2_prod)));

    courant_t abs_nu1;
    logic signed [FACTOR_W-1:0]   g1, g2;
    logic signed [2*FACTOR_W-1:0] c1_prod, c2_prod;
    logic signed [COEF_W-1:0]     c1_next, c2_next, c1_reg, c2_reg;
    coef_k_t                      k1_reg, k2_reg;

    assign abs_nu1 = nu1_reg[COURANT_BITS-1] ? -nu1_reg : nu1_reg;
    assign g1      = (FACTOR_W'(COURANT_ONE) <<< 1) - FACTOR_W'(abs_nu1);
    assign g2      = FACTOR_W'(COURANT_ONE) + FACTOR_W'(nu1_reg);
    assign c1_prod = p1_reg * g1;
    assign c2_prod = p2_reg * g2;
    assign c1_next = COEF_W'(round_q(wide_t'(c1_prod)));
    assign c2_next = COEF_W'(round_q(wide_t'(c2_prod)));

    sample_t center_reg [1:STAGES-2];

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            nu1_reg       <= nu0_reg;
            center_reg[1] <= win_reg[3];
        end
        if (load[2])
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
        end
        if (load[3])
        begin
            k1_reg <= div6_round(c1_reg);
            k2_reg <= div6_round(c2_reg);
        end
        for (int k = 2; k <= STAGES - 2; k++)
        begin
            if (load[k])
            begin
                center_reg[k] <= center_reg[k-1];
            end
        end
    end

    face_load_t face_load;
    sample_t    win_in  [WINDOW];
    sample_t    win_out [WINDOW];
    flux_t      flux_in, flux_exit;

    always_comb
    begin
        face_load.s1 = load[1];
        face_load.s2 = load[2];
        face_load.s3 = load[3];
        face_load.s4 = load[4];
        face_load.s5 = load[5];
        for (int n = 0; n < WINDOW; n++)
        begin
            win_in[n]  = win_reg[n];
            win_out[n] = win_reg[n+1];
        end
    end

    pfclacu_face_flux u_face_in (
        .clk  (clk),
        .load (face_load),
        .win  (win_in),
        .nu   (nu0_reg),
        .k1   (k1_reg),
        .k2   (k2_reg),
        .flux (flux_in)
    );

    pfclacu_face_flux u_face_out (
        .clk  (clk),
        .load (face_load),
        .win  (win_out),
        .nu   (nu0_reg),
        .k1   (k1_reg),
        .k2   (k2_reg),
        .flux (flux_exit)
    );

    logic signed [SUM_W-1:0] upd_sum;
    logic                    upd_ovf;
    sample_t                 upd_clip;
    sample_t                 updated_sample_reg;
    logic                    saturated_reg;

    always_comb
    begin
        upd_sum  = SUM_W'(center_reg[STAGES-2]) + SUM_W'(flux_in) - SUM_W'(flux_exit);
        upd_ovf  = upd_sum[SUM_W-1:SAMPLE_BITS-1]
                   != {(SUM_W-SAMPLE_BITS+1){upd_sum[SUM_W-1]}};
        upd_clip = upd_sum[SUM_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (load[STAGES-1])
        begin
            updated_sample_reg <= upd_ovf ? upd_clip : upd_sum[SAMPLE_BITS-1:0];
            saturated_reg      <= upd_ovf;
        end
    end

    assign updated_sample = updated_sample_reg;
    assign saturated      = saturated_reg;

    `PFC_ASSERT_IMP(a_stall_only_when_full, in_stall, (&valid_reg) && out_stall, "input held with a free stage")
    `PFC_ASSERT_IMP(a_courant_clamped, valid_reg[0], (nu0_reg <= COURANT_ONE) && (nu0_reg >= -COURANT_ONE), "Courant number outside clamp range")
    `PFC_ASSERT_IMP(a_sat_at_bound, out_valid && saturated, (updated_sample == SAMPLE_MAX) || (updated_sample == SAMPLE_MIN), "clipped result not at a bound")
    `PFC_ASSERT_IMP(a_out_from_last_stage, $rose(out_valid), $past(valid_reg[STAGES-2]), "result without a feeding stage")

endmodule
